// ----- sv/wsl_pkg.sv -----
// Shared types and constants for the wildcard socket lookup table.
`default_nettype none

package wsl_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int MAX_RESULTS         = 16;
    localparam int RES_CNT_W           = $clog2(MAX_RESULTS);

    localparam int REQ_W    = 2;
    localparam int ID_W     = 16;
    localparam int PROTO_W  = 16;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CONNECT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FIND    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    // Fields of one table entry that are written together by an add.
    typedef struct packed {
        logic [ID_W-1:0]    sock_id;
        logic [PROTO_W-1:0] proto_id;
        logic [ADDR_W-1:0]  local_addr;
    } wsl_entry_t;

    // Write enables for the two table memories.
    typedef struct packed {
        logic entry_we;
        logic remote_we;
    } wsl_we_t;

endpackage

`default_nettype wire

// ----- sv/wsl_table_mem.sv -----
// Table storage: entry memory and remote address memory, one read and one write port each.
`default_nettype none

module wsl_table_mem #(
    parameter int DEPTH = wsl_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX_W = 4
) (
    input  wire                         clk,
    input  wire                         rd_en,
    input  wire  [IDX_W-1:0]            rd_addr,
    output wsl_pkg::wsl_entry_t         rd_entry,
    output logic [wsl_pkg::ADDR_W-1:0]  rd_remote,
    input  wsl_pkg::wsl_we_t            we,
    input  wire  [IDX_W-1:0]            wr_addr,
    input  wsl_pkg::wsl_entry_t         wr_entry,
    input  wire  [wsl_pkg::ADDR_W-1:0]  wr_remote
);
    import wsl_pkg::*;

    wsl_entry_t        entry_mem [DEPTH];
    logic [ADDR_W-1:0] remote_mem [DEPTH];

    wsl_entry_t        rd_entry_reg;
    logic [ADDR_W-1:0] rd_remote_reg;

    always_ff @(posedge clk)
    begin
        if (we.entry_we)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
        if (we.remote_we)
        begin
            remote_mem[wr_addr] <= wr_remote;
        end
        if (rd_en)
        begin
            rd_entry_reg  <= entry_mem[rd_addr];
            rd_remote_reg <= remote_mem[rd_addr];
        end
    end

    assign rd_entry  = rd_entry_reg;
    assign rd_remote = rd_remote_reg;

endmodule

`default_nettype wire

// ----- sv/wildcard_socket_lookup_table.sv -----
// Wildcard socket lookup table: top level with the request sequencer and table memories.
// Add, connect and remove: one scan of the whole table, then the drain state, the write state when
// the table is written, and the emit state, which loads the result; the next transfer can be taken in the cycle after.
// A find takes one table pass per emitted result (at least one), since the table memory has a single
// read port; a stalled receiver holds the block in the emit state and so lengthens the find.
// Reset clears all valid marks at once; entry contents stay undefined until written.
`default_nettype none

module wildcard_socket_lookup_table #(
    parameter int TABLE_DEPTH = wsl_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire  [wsl_pkg::REQ_W-1:0]     req_type,
    input  wire  [wsl_pkg::ID_W-1:0]      sock_id,
    input  wire  [wsl_pkg::PROTO_W-1:0]   proto_id,
    input  wire  [wsl_pkg::ADDR_W-1:0]    local_addr,
    input  wire  [wsl_pkg::ADDR_W-1:0]    remote_addr,
    output logic                          out_valid,
    input  wire                           out_stall,
    output logic [wsl_pkg::STATUS_W-1:0]  status,
    output logic                          match_valid,
    output logic [wsl_pkg::ID_W-1:0]      match_sock_id,
    output logic                          last
);
    import wsl_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [RES_CNT_W-1:0] LAST_RES = RES_CNT_W'(MAX_RESULTS - 1);

    // Candidate count of a find pass saturates at two: we only need to know
    // whether the smallest candidate is the only one left.
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_MANY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE,
        S_EMIT
    } state_t;

    // Request registers, captured at the input transfer.
    state_t               state_reg, state_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic [ID_W-1:0]      qid_reg, qid_next;
    logic [PROTO_W-1:0]   qproto_reg, qproto_next;
    logic [ADDR_W-1:0]    qlocal_reg, qlocal_next;
    logic [ADDR_W-1:0]    qremote_reg, qremote_next;

    // Scan pipeline: the read issued in one cycle returns data in the next.
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;

    // Pass accumulators.
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     hit_slot_reg, hit_slot_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_slot_reg, free_slot_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic [ID_W-1:0]      min_id_reg, min_id_next;
    logic [ID_W-1:0]      prev_id_reg, prev_id_next;
    logic                 first_pass_reg, first_pass_next;
    logic [RES_CNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;

    // Valid marks, one flip-flop per slot.
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic                 out_mv_reg, out_mv_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic                 out_last_reg, out_last_next;

    // Memory interface.
    logic                 rd_en;
    wsl_entry_t           rd_entry;
    logic [ADDR_W-1:0]    rd_remote;
    wsl_we_t              mem_we;
    logic [IDX_W-1:0]     wr_addr;
    wsl_entry_t           wr_entry;
    logic [ADDR_W-1:0]    wr_remote;

    // Per-entry evaluation of the word that came back from the memory.
    logic                 ent_valid;
    logic                 ent_id_hit;
    logic                 ent_match;
    logic                 in_xfer;
    logic                 out_free;
    logic                 emit_last;

    wsl_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (scan_idx_reg),
        .rd_entry  (rd_entry),
        .rd_remote (rd_remote),
        .we        (mem_we),
        .wr_addr   (wr_addr),
        .wr_entry  (wr_entry),
        .wr_remote (wr_remote)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_en    = (state_reg == S_SCAN);

    // Valid marks do not change during a pass, so the mark of the slot whose
    // data is returning can be read directly.
    assign ent_valid  = rd_pend_reg && valid_reg[rd_idx_reg];
    assign ent_id_hit = ent_valid && (rd_entry.sock_id == qid_reg);

    // A zero address in the table is a wildcard. After the first result of
    // a find, only ids above the last one emitted are candidates; ids in the
    // table are unique, so this walks the matches in ascending order.
    assign ent_match = ent_valid
                    && (rd_entry.proto_id == qproto_reg)
                    && ((rd_entry.local_addr == '0) || (rd_entry.local_addr == qlocal_reg))
                    && ((rd_remote == '0) || (rd_remote == qremote_reg))
                    && (first_pass_reg || (rd_entry.sock_id > prev_id_reg));

    assign emit_last = (cnt_reg == CNT_ONE) || (emit_cnt_reg == LAST_RES);

    // Table writes happen only in the write state, where no read is in flight.
    assign wr_entry  = '{sock_id: qid_reg, proto_id: qproto_reg, local_addr: qlocal_reg};
    assign wr_remote = (req_reg == REQ_CONNECT) ? qremote_reg : '0;
    assign wr_addr   = (req_reg == REQ_ADD) ? free_slot_reg : hit_slot_reg;

    always_comb
    begin
        mem_we.entry_we  = 1'b0;
        mem_we.remote_we = 1'b0;
        if (state_reg == S_WRITE)
        begin
            mem_we.entry_we  = (req_reg == REQ_ADD);
            mem_we.remote_we = (req_reg == REQ_ADD) || (req_reg == REQ_CONNECT);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        qid_next        = qid_reg;
        qproto_next     = qproto_reg;
        qlocal_next     = qlocal_reg;
        qremote_next    = qremote_reg;
        scan_idx_next   = scan_idx_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        cnt_next        = cnt_reg;
        min_id_next     = min_id_reg;
        prev_id_next    = prev_id_reg;
        first_pass_next = first_pass_reg;
        emit_cnt_next   = emit_cnt_reg;
        res_status_next = res_status_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_mv_next     = out_mv_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;

        // Fold the returning entry into the pass accumulators.
        if (ent_id_hit)
        begin
            hit_next      = 1'b1;
            hit_slot_next = rd_idx_reg;
        end
        if (rd_pend_reg && !valid_reg[rd_idx_reg] && !free_found_reg)
        begin
            free_found_next = 1'b1;
            free_slot_next  = rd_idx_reg;
        end
        if (ent_match)
        begin
            if (cnt_reg == CNT_NONE)
            begin
                cnt_next    = CNT_ONE;
                min_id_next = rd_entry.sock_id;
            end
            else
            begin
                cnt_next = CNT_MANY;
                if (rd_entry.sock_id < min_id_reg)
                begin
                    min_id_next = rd_entry.sock_id;
                end
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    req_next        = req_type;
                    qid_next        = sock_id;
                    qproto_next     = proto_id;
                    qlocal_next     = local_addr;
                    qremote_next    = remote_addr;
                    scan_idx_next   = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    cnt_next        = CNT_NONE;
                    first_pass_next = 1'b1;
                    emit_cnt_next   = '0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                rd_pend_next = 1'b1;
                rd_idx_next  = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            S_DRAIN:
            begin
                // The last entry of the pass is folded in this cycle, so the
                // decision looks at the updated accumulators.
                res_status_next = STATUS_OK;
                state_next      = S_EMIT;
                case (req_reg)
                    REQ_ADD:
                    begin
                        if (hit_next)
                        begin
                            res_status_next = STATUS_DUPLICATE;
                        end
                        else if (!free_found_next)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            state_next = S_WRITE;
                        end
                    end
                    REQ_CONNECT, REQ_REMOVE:
                    begin
                        if (hit_next)
                        begin
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            res_status_next = STATUS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_status_next = STATUS_OK;
                    end
                endcase
            end

            S_WRITE:
            begin
                if (req_reg == REQ_ADD)
                begin
                    valid_next[free_slot_reg] = 1'b1;
                end
                else if (req_reg == REQ_REMOVE)
                begin
                    valid_next[hit_slot_reg] = 1'b0;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    if ((req_reg == REQ_FIND) && (cnt_reg != CNT_NONE))
                    begin
                        out_mv_next   = 1'b1;
                        out_id_next   = min_id_reg;
                        out_last_next = emit_last;
                        if (emit_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // Start the next pass for the following larger id.
                            prev_id_next    = min_id_reg;
                            first_pass_next = 1'b0;
                            cnt_next        = CNT_NONE;
                            emit_cnt_next   = emit_cnt_reg + 1'b1;
                            scan_idx_next   = '0;
                            state_next      = S_SCAN;
                        end
                    end
                    else
                    begin
                        out_mv_next   = 1'b0;
                        out_id_next   = '0;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_pend_reg    <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pend_reg    <= rd_pend_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        qid_reg        <= qid_next;
        qproto_reg     <= qproto_next;
        qlocal_reg     <= qlocal_next;
        qremote_reg    <= qremote_next;
        scan_idx_reg   <= scan_idx_next;
        rd_idx_reg     <= rd_idx_next;
        hit_reg        <= hit_next;
        hit_slot_reg   <= hit_slot_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        cnt_reg        <= cnt_next;
        min_id_reg     <= min_id_next;
        prev_id_reg    <= prev_id_next;
        first_pass_reg <= first_pass_next;
        emit_cnt_reg   <= emit_cnt_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_mv_reg     <= out_mv_next;
        out_id_reg     <= out_id_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign match_valid   = out_mv_reg;
    assign match_sock_id = out_id_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire

// ----- dv/wsl_reply_checker.sv -----
`timescale 1ns / 1ps
// Transfer monitor, socket table predictor and reply comparator for the lookup table.
module wsl_reply_checker #(
    parameter int TABLE_DEPTH = wsl_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    input  wire                           in_stall,
    input  wire  [wsl_pkg::REQ_W-1:0]     req_type,
    input  wire  [wsl_pkg::ID_W-1:0]      sock_id,
    input  wire  [wsl_pkg::PROTO_W-1:0]   proto_id,
    input  wire  [wsl_pkg::ADDR_W-1:0]    local_addr,
    input  wire  [wsl_pkg::ADDR_W-1:0]    remote_addr,
    input  wire                           out_valid,
    input  wire                           out_stall,
    input  wire  [wsl_pkg::STATUS_W-1:0]  status,
    input  wire                           match_valid,
    input  wire  [wsl_pkg::ID_W-1:0]      match_sock_id,
    input  wire                           last,
    output int                            fail_count,
    output int                            replies_waiting
);
    import wsl_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                match_valid;
        logic [ID_W-1:0]     match_sock_id;
        logic                last;
    } socket_reply_t;

    // Shadow copy of the socket table.
    logic               slot_used   [TABLE_DEPTH];
    logic [ID_W-1:0]    slot_id     [TABLE_DEPTH];
    logic [PROTO_W-1:0] slot_proto  [TABLE_DEPTH];
    logic [ADDR_W-1:0]  slot_local  [TABLE_DEPTH];
    logic [ADDR_W-1:0]  slot_remote [TABLE_DEPTH];

    socket_reply_t socket_replies[$];
    int            fail_total;

    function automatic socket_reply_t make_reply(input logic [STATUS_W-1:0] st,
                                                 input logic mv,
                                                 input logic [ID_W-1:0] id,
                                                 input logic fin);
        socket_reply_t r;
        r.status        = st;
        r.match_valid   = mv;
        r.match_sock_id = id;
        r.last          = fin;
        return r;
    endfunction

    // Appends one expected reply at the tail of the queue.
    function automatic void queue_reply(input socket_reply_t r);
        socket_replies.insert(socket_replies.size(), r);
    endfunction

    function automatic int find_slot(input logic [ID_W-1:0] id);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (slot_used[i] && slot_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    // Applies one request to the shadow table and queues the replies it causes.
    task automatic run_socket_request(input logic [REQ_W-1:0]   req,
                                      input logic [ID_W-1:0]    id,
                                      input logic [PROTO_W-1:0] proto,
                                      input logic [ADDR_W-1:0]  laddr,
                                      input logic [ADDR_W-1:0]  raddr);
        int              slot;
        int              hits;
        int              j;
        logic [ID_W-1:0] hit_ids [TABLE_DEPTH];
        slot = find_slot(id);
        hits = 0;
        case (req)
            REQ_ADD:
            begin
                if (slot >= 0)
                begin
                    queue_reply(make_reply(STATUS_DUPLICATE, 1'b0, '0, 1'b1));
                end
                else
                begin
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                    begin
                        if (!slot_used[i])
                            slot = i;
                    end
                    if (slot < 0)
                    begin
                        queue_reply(make_reply(STATUS_FULL, 1'b0, '0, 1'b1));
                    end
                    else
                    begin
                        slot_used[slot]   = 1'b1;
                        slot_id[slot]     = id;
                        slot_proto[slot]  = proto;
                        slot_local[slot]  = laddr;
                        slot_remote[slot] = '0;
                        queue_reply(make_reply(STATUS_OK, 1'b0, '0, 1'b1));
                    end
                end
            end
            REQ_CONNECT, REQ_REMOVE:
            begin
                if (slot < 0)
                begin
                    queue_reply(make_reply(STATUS_NOT_FOUND, 1'b0, '0, 1'b1));
                end
                else
                begin
                    if (req == REQ_CONNECT)
                        slot_remote[slot] = raddr;
                    else
                        slot_used[slot] = 1'b0;
                    queue_reply(make_reply(STATUS_OK, 1'b0, '0, 1'b1));
                end
            end
            default:
            begin
                // Find: collect matching ids in ascending order by insertion.
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (slot_used[i] && slot_proto[i] == proto &&
                        (slot_local[i] == '0 || slot_local[i] == laddr) &&
                        (slot_remote[i] == '0 || slot_remote[i] == raddr))
                    begin
                        j = hits;
                        while (j > 0 && hit_ids[j-1] > slot_id[i])
                        begin
                            hit_ids[j] = hit_ids[j-1];
                            j--;
                        end
                        hit_ids[j] = slot_id[i];
                        hits++;
                    end
                end
                if (hits == 0)
                begin
                    queue_reply(make_reply(STATUS_OK, 1'b0, '0, 1'b1));
                end
                else
                begin
                    if (hits > MAX_RESULTS)
                        hits = MAX_RESULTS;
                    for (int k = 0; k < hits; k++)
                        queue_reply(make_reply(STATUS_OK, 1'b1, hit_ids[k], k == hits - 1));
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : reply_check
        socket_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                slot_used[i] = 1'b0;
            socket_replies.delete();
            fail_total = 0;
            fail_count      <= 0;
            replies_waiting <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                run_socket_request(req_type, sock_id, proto_id, local_addr, remote_addr);
            if (out_valid && !out_stall)
            begin
                if (socket_replies.size() == 0)
                begin
                    $error("reply with no request waiting: status %0d, match %0d, id 0x%04h",
                           status, match_valid, match_sock_id);
                    fail_total++;
                end
                else
                begin
                    want = socket_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_total++;
                    end
                    if (match_valid !== want.match_valid)
                    begin
                        $error("match_valid: expected %0d, got %0d",
                               want.match_valid, match_valid);
                        fail_total++;
                    end
                    if (match_sock_id !== want.match_sock_id)
                    begin
                        $error("match_sock_id: expected 0x%04h, got 0x%04h",
                               want.match_sock_id, match_sock_id);
                        fail_total++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        fail_total++;
                    end
                end
            end
            fail_count      <= fail_total;
            replies_waiting <= socket_replies.size();
        end
    end

endmodule

// ----- dv/wildcard_socket_lookup_table_test.sv -----
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, request stimulus, reply stalls and the verdict.
module wildcard_socket_lookup_table_test;
    import wsl_pkg::*;

    localparam int TABLE_DEPTH        = DEFAULT_TABLE_DEPTH;
    localparam int RANDOM_REQUESTS    = 300;
    localparam int REQUESTS_PER_PHASE = RANDOM_REQUESTS / 3;
    // The slowest correct run has every request a find with MAX_RESULTS replies, each
    // reply taking a full table pass plus whatever the receiver stall adds; the limit
    // is well above that.
    localparam int CYCLE_LIMIT        = 1_000_000;
    // Quiet time after the last reply, so a stray extra reply still gets caught.
    localparam int SETTLE_CYCLES      = 4 * (TABLE_DEPTH + 3);

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type;
    logic [ID_W-1:0]     sock_id;
    logic [PROTO_W-1:0]  proto_id;
    logic [ADDR_W-1:0]   local_addr;
    logic [ADDR_W-1:0]   remote_addr;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic                match_valid;
    logic [ID_W-1:0]     match_sock_id;
    logic                last;

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int send_idle_pct = 24;
    int recv_idle_pct = 53;
    int cycle_count   = 0;
    int fail_count;
    int replies_waiting;

    wildcard_socket_lookup_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .sock_id       (sock_id),
        .proto_id      (proto_id),
        .local_addr    (local_addr),
        .remote_addr   (remote_addr),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .match_valid   (match_valid),
        .match_sock_id (match_sock_id),
        .last          (last)
    );

    // The checker sees both channels exactly as the block does and reports back how
    // many checks failed and how many replies are still owed.
    wsl_reply_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .sock_id         (sock_id),
        .proto_id        (proto_id),
        .local_addr      (local_addr),
        .remote_addr     (remote_addr),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .match_valid     (match_valid),
        .match_sock_id   (match_sock_id),
        .last            (last),
        .fail_count      (fail_count),
        .replies_waiting (replies_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a reply.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver stalls at random, one decision per cycle, changed at the falling edge.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = (int'($urandom_range(99)) < recv_idle_pct);
        end
    end

    // Ids come mostly from a pool a bit larger than the table, so that adds collide,
    // the table fills up, and connects and removes usually find their target.
    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return ID_W'($urandom);
            default: return ID_W'(16'h0100 + $urandom_range(19));
        endcase
    endfunction

    // A few common protocols keep finds hitting several sockets at once.
    function automatic logic [PROTO_W-1:0] pick_proto();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return PROTO_W'($urandom);
            3, 4, 5: return PROTO_W'(6);
            default: return PROTO_W'(17);
        endcase
    endfunction

    // Zero is the wildcard address; the rest are a couple of hosts and noise.
    function automatic logic [ADDR_W-1:0] pick_addr();
        case ($urandom_range(9))
            0, 1, 2: return '0;
            3:       return '1;
            4:       return ADDR_W'($urandom);
            5, 6:    return 32'h0A00_0001;
            default: return 32'h0A00_0002;
        endcase
    endfunction

    // Presents one request from a falling edge and returns at the falling edge after
    // its transfer. Valid stays high into the next request unless the sender idles.
    task automatic send_request(input logic [REQ_W-1:0]   req,
                                input logic [ID_W-1:0]    id,
                                input logic [PROTO_W-1:0] proto,
                                input logic [ADDR_W-1:0]  laddr,
                                input logic [ADDR_W-1:0]  raddr);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        req_type    = req;
        sock_id     = id;
        proto_id    = proto;
        local_addr  = laddr;
        remote_addr = raddr;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    initial
    begin
        int roll;
        in_valid    = 1'b0;
        req_type    = REQ_ADD;
        sock_id     = '0;
        proto_id    = '0;
        local_addr  = '0;
        remote_addr = '0;
        rst_n       = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. An empty table gives a no-match find and not-found errors.
        send_request(REQ_FIND, '0, '0, '0, '0);
        send_request(REQ_CONNECT, 16'h0042, '0, '0, 32'h0A00_0001);
        send_request(REQ_REMOVE, 16'h0042, '0, '0, '0);

        // Extreme ids: one socket bound to the all-ones address, one to the wildcard.
        // Add ignores the remote address, so it is set to all ones to prove that.
        send_request(REQ_ADD, '1, '1, '1, '1);
        send_request(REQ_ADD, '0, '1, '0, '1);
        send_request(REQ_ADD, '1, 16'h0006, 32'h0A00_0001, '0);
        send_request(REQ_CONNECT, '0, '0, '0, '1);

        // Both match here, and the lower id must come out first.
        send_request(REQ_FIND, 16'h1234, '1, '1, '1);
        // A different local address leaves only the wildcard-bound socket.
        send_request(REQ_FIND, '1, '1, 32'h0000_0001, '1);

        // Fill the table with descending ids so that slot order and id order differ.
        for (int k = 0; k < TABLE_DEPTH - 2; k++)
            send_request(REQ_ADD, 16'h7000 - ID_W'(k * 16'h0111), '1, '0, '0);

        // With the table full, a duplicate is reported ahead of the full condition.
        send_request(REQ_ADD, 16'h7000, '1, '0, '0);
        send_request(REQ_ADD, 16'h4321, '1, '0, '0);
        // Every socket matches: the largest possible burst of replies.
        send_request(REQ_FIND, '0, '1, '1, '1);
        // Free a slot in the middle and take it again.
        send_request(REQ_REMOVE, 16'h7000 - 16'h0333, '0, '0, '0);
        send_request(REQ_ADD, 16'h0101, 16'h0006, 32'h0A00_0001, '0);

        // Random part in three phases: sender idles less than the receiver stalls,
        // then the reverse, then both run flat out.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 53;
                end
                1:
                begin
                    send_idle_pct = 53;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < REQUESTS_PER_PHASE; n++)
            begin
                roll = $urandom_range(99);
                // Fields that a request does not use still carry random bits.
                if (roll < 35)
                    send_request(REQ_ADD, pick_id(), pick_proto(), pick_addr(),
                                 ADDR_W'($urandom));
                else if (roll < 55)
                    send_request(REQ_CONNECT, pick_id(), PROTO_W'($urandom),
                                 ADDR_W'($urandom), pick_addr());
                else if (roll < 75)
                    send_request(REQ_REMOVE, pick_id(), PROTO_W'($urandom),
                                 ADDR_W'($urandom), ADDR_W'($urandom));
                else
                    send_request(REQ_FIND, ID_W'($urandom), pick_proto(), pick_addr(),
                                 pick_addr());
            end
        end
        in_valid = 1'b0;

        // Drain every owed reply, then watch a while longer for anything extra.
        while (replies_waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && replies_waiting == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
